>>> hw/rtl/crc32c_pkg.sv
// shared types, constants and fold tables for the crc-32c chunk engine
package crc32c_pkg;

  // reflected castagnoli polynomial and the final xor
  localparam logic [31:0] Poly   = 32'h82F6_3B78;
  localparam logic [31:0] XorOut = 32'hFFFF_FFFF;

  // bytes in one chunk and derived widths
  localparam int ChunkBytes = 16;
  localparam int ChunkBits  = ChunkBytes * 8;
  localparam int CountW     = 5;

  // one chunk as it enters the fold logic
  typedef struct packed {
    logic [ChunkBits-1:0] bytes;
    logic [CountW-1:0]    count;
  } chunk_t;

  // column tables of the linear update
  typedef logic [ChunkBytes:0][31:0][31:0] shift_tab_t;
  typedef logic [ChunkBits-1:0][31:0]      data_tab_t;

  // bit-serial crc over nbytes bytes, lowest byte first, elaboration use only
  function automatic logic [31:0] crc_advance(logic [31:0] acc_in,
                                              logic [ChunkBits-1:0] data,
                                              int nbytes);
    logic [31:0] acc;
    acc = acc_in;
    for (int i = 0; i < nbytes; i++) begin
      acc = acc ^ {24'h0, data[8*i +: 8]};
      for (int b = 0; b < 8; b++) begin
        if (acc[0]) acc = (acc >> 1) ^ Poly;
        else        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  // state advanced over n zero bytes, one column per state bit
  function automatic shift_tab_t build_shift_tab();
    shift_tab_t tab;
    for (int n = 0; n <= ChunkBytes; n++) begin
      for (int j = 0; j < 32; j++) begin
        tab[n][j] = crc_advance(32'(1) << j, '0, n);
      end
    end
    return tab;
  endfunction

  // zero-state crc of a full chunk with a single data bit set
  function automatic data_tab_t build_data_tab();
    data_tab_t tab;
    for (int k = 0; k < ChunkBits; k++) begin
      tab[k] = crc_advance('0, ChunkBits'(1) << k, ChunkBytes);
    end
    return tab;
  endfunction

  localparam shift_tab_t ShiftTab = build_shift_tab();
  localparam data_tab_t  DataTab  = build_data_tab();

endpackage

>>> hw/rtl/crc32c_update.sv
// combinational crc-32c state update over the valid bytes of one chunk
module crc32c_update (
  input  logic [31:0]          base,     // state before the chunk
  input  crc32c_pkg::chunk_t   chunk,
  output logic [31:0]          acc_new   // state after the chunk
);
  import crc32c_pkg::*;

  logic [CountW-1:0]    n_bytes;
  logic [CountW-1:0]    pad_bytes;
  logic [ChunkBits-1:0] aligned;
  logic [31:0]          state_part;
  logic [31:0]          data_part;

  // clamp the byte count to a full chunk
  always_comb begin
    if (chunk.count > CountW'(ChunkBytes)) n_bytes = CountW'(ChunkBytes);
    else                                   n_bytes = chunk.count;
    pad_bytes = CountW'(ChunkBytes) - n_bytes;
  end

  // push valid bytes to the top, leading zero bytes leave a zero state alone
  assign aligned = chunk.bytes << {pad_bytes, 3'b000};

  // old state carried across n bytes
  always_comb begin
    state_part = '0;
    for (int j = 0; j < 32; j++) begin
      if (base[j]) state_part = state_part ^ ShiftTab[n_bytes][j];
    end
  end

  // zero-state crc of the aligned data
  always_comb begin
    data_part = '0;
    for (int k = 0; k < ChunkBits; k++) begin
      if (aligned[k]) data_part = data_part ^ DataTab[k];
    end
  end

  assign acc_new = state_part ^ data_part;

endmodule

>>> hw/rtl/crc32c_chunk_engine.sv
// crc-32c engine over 16-byte chunks with stream handshakes on both sides
//
// A message enters as a run of requests on the s_ channel, one 16-byte chunk
// each, byte 0 in the lowest bits of s_tdata. s_tuser marks the first chunk,
// whose seed field (a prior finished crc, or 0) starts the state; s_tlast
// marks the final chunk. The byte count picks the valid bytes from byte 0 up,
// counts above 16 act as 16. Only the final chunk yields a request on the m_
// channel carrying the finished crc.
// Throughput: one chunk per cycle while s_tready is high. The state register
// and its update network close the loop with no other register in it, so
// chunks may arrive back to back without gaps. A final chunk is taken into
// the input register, and its result is then registered in the output
// register, which drives m_tvalid.
// Reset (rst, synchronous) empties both registers and sets the state to all
// ones, so a chunk without the first flag begins a message with seed 0.
// When m_tready is low a result waits in the output register; non-final
// chunks keep flowing, and s_tready drops only while a second final chunk
// waits behind the held result.
module crc32c_chunk_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_low [63:0], data_high [127:64], byte_count [132:128],
  // seed [164:133], zero [167:165]
  input  logic [167:0] s_tdata,
  // first [0]
  input  logic [0:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // crc_value [31:0]
  output logic [31:0]  m_tdata
);
  import crc32c_pkg::*;

  logic               in_valid;
  chunk_t             in_chunk;
  logic               in_first;
  logic [31:0]        in_seed;
  logic               in_last;
  logic [31:0]        acc;
  logic [31:0]        base;
  logic [31:0]        acc_new;
  logic               adv;
  logic               out_valid;
  logic [31:0]        crc;

  // input register moves on unless a final chunk waits for the output slot
  assign adv      = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_chunk.bytes <= s_tdata[127:0];
      in_chunk.count <= s_tdata[132:128];
      in_seed        <= s_tdata[164:133];
      in_first       <= s_tuser[0];
      in_last        <= s_tlast;
    end
  end

  // start value: seed on a first chunk, running state otherwise
  assign base = in_first ? (in_seed ^ XorOut) : acc;

  crc32c_update u_update (
    .base    (base),
    .chunk   (in_chunk),
    .acc_new (acc_new)
  );

  // running state, back to all ones after a final chunk
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= XorOut;
    end else if (adv) begin
      if (in_last) acc <= XorOut;
      else         acc <= acc_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (adv && in_last) begin
      crc <= acc_new ^ XorOut;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = crc;

`ifndef ASSERT_OFF
  // a chunk stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |-> (in_last && out_valid && !m_tready))
    else $error("input stalled without a held result");

  // back pressure on the input only while a result is pending
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("s_tready low with no pending result");

  // state restarts after a final chunk
  a_acc_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> (acc == XorOut))
    else $error("state not reset after final chunk");

  // a result appears only from a final chunk
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(adv && in_last))
    else $error("result without a final chunk");

  // a non-final chunk never creates a result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && !in_last && !out_valid) |=> !m_tvalid)
    else $error("result from a non-final chunk");
`endif

endmodule
